>>> sv/smv_pkg.sv
// ----------------------------------------------------------------------------
// smv_pkg
// Shared types and constants of the sparse matrix-vector block.
// ----------------------------------------------------------------------------
`default_nettype none

package smv_pkg;

   localparam int unsigned VECTOR_DEPTH_DEF = 4096;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned CELL_W   = 12;
   localparam int unsigned DBL_W    = 64;
   localparam int unsigned DIM_W    = 7;
   localparam int unsigned HALO_W   = 4;
   localparam int unsigned CSR_IW   = 2;
   localparam int unsigned CSR_DW   = 7;

   // commands
   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ELEMENT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ROW_END = 2'd2;

   // register indexes
   localparam logic [CSR_IW-1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IW-1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IW-1:0] REG_HALO_DEPTH  = 2'd2;

   localparam logic [DIM_W-1:0]  GRID_WIDTH_RST  = 7'd64;
   localparam logic [DIM_W-1:0]  GRID_HEIGHT_RST = 7'd64;
   localparam logic [HALO_W-1:0] HALO_DEPTH_RST  = 4'd2;

   localparam logic [DBL_W-1:0] DBL_POS_ZERO = 64'h0000_0000_0000_0000;

   typedef enum logic {
      FOP_MUL = 1'b0,
      FOP_ADD = 1'b1
   } fop_type;

   typedef struct packed {
      logic    start;
      fop_type op;
   } fpu_req_type;

endpackage

`default_nettype wire

>>> sv/smv_vmem.sv
// ----------------------------------------------------------------------------
// smv_vmem
// Vector memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smv_vmem #(
   parameter int unsigned DEPTH = smv_pkg::VECTOR_DEPTH_DEF,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic [smv_pkg::DBL_W-1:0] wr_data,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            rd_addr,
   output logic      [smv_pkg::DBL_W-1:0] rd_data
);

   logic [smv_pkg::DBL_W-1:0] mem [DEPTH];
   logic [smv_pkg::DBL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/smv_fpu.sv
// ----------------------------------------------------------------------------
// smv_fpu
// Shared multi-cycle double unit: multiply or add, round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

module smv_fpu (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire smv_pkg::fpu_req_type      req,
   input  wire logic [smv_pkg::DBL_W-1:0] a_i,
   input  wire logic [smv_pkg::DBL_W-1:0] b_i,
   output logic                           done_o,
   output logic      [smv_pkg::DBL_W-1:0] res_o
);

   localparam logic [63:0] DEF_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QBIT    = 64'h0008_0000_0000_0000;

   typedef enum logic [6:0] {
      F_IDLE  = 7'b0000001,
      F_PP    = 7'b0000010,
      F_ALIGN = 7'b0000100,
      F_NORM  = 7'b0001000,
      F_RSH   = 7'b0010000,
      F_RND   = 7'b0100000,
      F_DONE  = 7'b1000000
   } fst_type;

   fst_type            st_ff, st_in;
   logic [63:0]        a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic [105:0]       s_ff, s_in;
   logic signed [12:0] e_ff, e_in;
   logic               sign_ff, sign_in, zsign_ff, zsign_in;
   logic [2:0]         k_ff, k_in;
   logic [53:0]        pp_ff, pp_in;

   // operand decode at start
   logic        sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
   logic [10:0] ea, eb;
   logic [63:0] spec;
   logic        is_spec;

   // partial products
   logic [52:0]  ma, mb;
   logic [26:0]  pa, pb;
   logic [105:0] pp_sh;

   // alignment
   logic         a_big;
   logic [63:0]  xo, yo;
   logic [10:0]  ex, ey, dexp;
   logic [5:0]   dd;
   logic [55:0]  sx, sy, sy_sh;
   logic         sy_lost;
   logic [56:0]  sum57;

   // right shift and rounding
   logic signed [12:0] rsh;
   logic [6:0]         rsh7;
   logic               r_lost, rup, carry;
   logic [52:0]        sig;
   logic signed [12:0] er;

   always_comb begin
      sa     = a_i[63];
      sb     = b_i[63];
      ea     = a_i[62:52];
      eb     = b_i[62:52];
      nan_a  = (ea == 11'h7FF) && (a_i[51:0] != '0);
      nan_b  = (eb == 11'h7FF) && (b_i[51:0] != '0);
      inf_a  = (ea == 11'h7FF) && (a_i[51:0] == '0);
      inf_b  = (eb == 11'h7FF) && (b_i[51:0] == '0);
      zero_a = (a_i[62:0] == '0);
      zero_b = (b_i[62:0] == '0);
      is_spec = 1'b1;
      spec    = DEF_NAN;
      if (nan_a) begin
         spec = a_i | QBIT;
      end else if (nan_b) begin
         spec = b_i | QBIT;
      end else if (req.op == smv_pkg::FOP_MUL) begin
         if (inf_a || inf_b) begin
            spec = (zero_a || zero_b) ? DEF_NAN : {sa ^ sb, 11'h7FF, 52'd0};
         end else begin
            is_spec = 1'b0;
         end
      end else begin
         if (inf_a && inf_b && (sa != sb)) begin
            spec = DEF_NAN;
         end else if (inf_a) begin
            spec = a_i;
         end else if (inf_b) begin
            spec = b_i;
         end else begin
            is_spec = 1'b0;
         end
      end
   end

   always_comb begin
      ma = {a_ff[62:52] != 11'd0, a_ff[51:0]};
      mb = {b_ff[62:52] != 11'd0, b_ff[51:0]};
      case (k_ff)
         3'd0:    begin pa = ma[26:0];          pb = mb[26:0];          end
         3'd1:    begin pa = ma[26:0];          pb = {1'b0, mb[52:27]}; end
         3'd2:    begin pa = {1'b0, ma[52:27]}; pb = mb[26:0];          end
         default: begin pa = {1'b0, ma[52:27]}; pb = {1'b0, mb[52:27]}; end
      endcase
      case (k_ff)
         3'd1:    pp_sh = 106'(pp_ff);
         3'd2:    pp_sh = 106'(pp_ff) << 27;
         3'd3:    pp_sh = 106'(pp_ff) << 27;
         default: pp_sh = 106'(pp_ff) << 54;
      endcase
   end

   always_comb begin
      a_big   = a_ff[62:0] >= b_ff[62:0];
      xo      = a_big ? a_ff : b_ff;
      yo      = a_big ? b_ff : a_ff;
      ex      = (xo[62:52] == 11'd0) ? 11'd1 : xo[62:52];
      ey      = (yo[62:52] == 11'd0) ? 11'd1 : yo[62:52];
      dexp    = ex - ey;
      dd      = (dexp > 11'd63) ? 6'd63 : dexp[5:0];
      sx      = {xo[62:52] != 11'd0, xo[51:0], 3'b000};
      sy      = {yo[62:52] != 11'd0, yo[51:0], 3'b000};
      sy_sh   = sy >> dd;
      sy_lost = |(sy & ~({56{1'b1}} << dd));
      if (xo[63] != yo[63]) begin
         sum57 = {1'b0, sx} - {1'b0, sy_sh | 56'(sy_lost)};
      end else begin
         sum57 = {1'b0, sx} + {1'b0, sy_sh | 56'(sy_lost)};
      end
   end

   always_comb begin
      rsh    = 13'sd1 - e_ff;
      rsh7   = rsh[6:0];
      r_lost = |(s_ff & ~({106{1'b1}} << rsh7));
      rup    = s_ff[52] && ((|s_ff[51:0]) || s_ff[53]);
      {carry, sig} = {1'b0, s_ff[105:53]} + 54'(rup);
      er = e_ff;
      if (carry) begin
         sig = {1'b1, 52'd0};
         er  = e_ff + 13'sd1;
      end
   end

   always_comb begin
      st_in    = st_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      res_in   = res_ff;
      s_in     = s_ff;
      e_in     = e_ff;
      sign_in  = sign_ff;
      zsign_in = zsign_ff;
      k_in     = k_ff;
      pp_in    = pp_ff;
      case (st_ff)
         F_IDLE: begin
         end
         F_PP: begin
            if (k_ff != 3'd4) begin
               pp_in = pa * pb;
            end
            if (k_ff != 3'd0) begin
               s_in = s_ff + pp_sh;
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd4) begin
               st_in = F_NORM;
            end
         end
         F_ALIGN: begin
            s_in     = {sum57, 49'd0};
            e_in     = $signed({2'b00, ex}) + 13'sd1;
            sign_in  = xo[63];
            zsign_in = a_ff[63] & b_ff[63];
            st_in    = F_NORM;
         end
         F_NORM: begin
            if (s_ff == '0) begin
               res_in = {zsign_ff, 63'd0};
               st_in  = F_DONE;
            end else if ((s_ff[105:90] == '0) && (e_ff > 13'sd16)) begin
               s_in = s_ff << 16;
               e_in = e_ff - 13'sd16;
            end else if (!s_ff[105] && (e_ff > 13'sd1)) begin
               s_in = s_ff << 1;
               e_in = e_ff - 13'sd1;
            end else begin
               st_in = F_RSH;
            end
         end
         F_RSH: begin
            if (e_ff < 13'sd1) begin
               if (rsh >= 13'sd106) begin
                  s_in = {105'd0, |s_ff};
               end else begin
                  s_in = (s_ff >> rsh7) | 106'(r_lost);
               end
               e_in = 13'sd1;
            end
            st_in = F_RND;
         end
         F_RND: begin
            if (er >= 13'sd2047) begin
               res_in = {sign_ff, 11'h7FF, 52'd0};
            end else begin
               res_in = {sign_ff, sig[52] ? er[10:0] : 11'd0, sig[51:0]};
            end
            st_in = F_DONE;
         end
         F_DONE: begin
            st_in = F_IDLE;
         end
         default: begin
            st_in = F_IDLE;
         end
      endcase
      if (req.start) begin
         a_in = a_i;
         b_in = b_i;
         if (is_spec) begin
            res_in = spec;
            st_in  = F_DONE;
         end else if (req.op == smv_pkg::FOP_MUL) begin
            e_in = $signed({2'b00, (ea == 11'd0) ? 11'd1 : ea})
                 + $signed({2'b00, (eb == 11'd0) ? 11'd1 : eb}) - 13'sd1022;
            sign_in  = sa ^ sb;
            zsign_in = sa ^ sb;
            s_in     = '0;
            k_in     = 3'd0;
            st_in    = F_PP;
         end else begin
            st_in = F_ALIGN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      res_ff   <= res_in;
      s_ff     <= s_in;
      e_ff     <= e_in;
      sign_ff  <= sign_in;
      zsign_ff <= zsign_in;
      k_ff     <= k_in;
      pp_ff    <= pp_in;
   end

   assign done_o = (st_ff == F_DONE);
   assign res_o  = res_ff;

endmodule

`default_nettype wire

>>> sv/sparse_matvec_with_dot.sv
// ----------------------------------------------------------------------------
// sparse_matvec_with_dot
// Sparse matrix-vector product w = A*p with running dot product p.w.
//
// Input: command transfer on start while busy is low. A load writes p into
// the vector memory in the accepting cycle and busy stays low, so loads go
// at one per cycle. A matrix element reads p at its column, multiplies and
// adds into the row sum in the shared double unit (four partial products,
// normalize, round). A row end reads p at the row cell and runs a second
// multiply and add into the dot sum. Subnormal operands add normalize
// steps to each operation.
// Output: rsp_valid marks one result for exactly one cycle; the receiver
// has no way to stall it, and the block is idle again in that same cycle.
// Configuration: csr_valid/csr_ready transfer, taken while not busy; any
// write to a known register restarts the pass. The vector memory is kept.
// Reset: registers to their defaults, pass restarted, vector memory left
// unwritten (no clearing pass).
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_matvec_with_dot #(
   parameter int unsigned VECTOR_DEPTH = smv_pkg::VECTOR_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [smv_pkg::CMD_W-1:0]  req_command,
   input  wire logic [smv_pkg::CELL_W-1:0] req_cell_index,
   input  wire logic [smv_pkg::DBL_W-1:0]  req_element_value,
   input  wire logic                       req_row_end,
   output logic                            rsp_valid,
   output logic      [smv_pkg::DBL_W-1:0]  rsp_row_product,
   output logic      [smv_pkg::CELL_W-1:0] rsp_row_cell,
   output logic      [smv_pkg::DBL_W-1:0]  rsp_dot_sum,
   output logic                            rsp_last,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [smv_pkg::CSR_IW-1:0] csr_index,
   input  wire logic [smv_pkg::CSR_DW-1:0] csr_data
);

   localparam int unsigned AW = $clog2(VECTOR_DEPTH);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_E_MUL = 8'b00000010,
      ST_E_MW  = 8'b00000100,
      ST_E_AW  = 8'b00001000,
      ST_R_RD  = 8'b00010000,
      ST_R_MUL = 8'b00100000,
      ST_R_MW  = 8'b01000000,
      ST_R_AW  = 8'b10000000
   } st_type;

   st_type                        st_ff, st_in;
   logic [smv_pkg::DBL_W-1:0]     value_ff, row_sum_ff, row_sum_in, dot_ff, dot_in;
   logic                          row_end_ff;
   logic [smv_pkg::DIM_W-1:0]     gw_ff, gw_in, gh_ff, gh_in, col_ff, col_in, row_ff, row_in;
   logic [smv_pkg::HALO_W-1:0]    hd_ff, hd_in;
   logic                          rsp_valid_ff;
   logic [smv_pkg::DBL_W-1:0]     rsp_prod_ff, rsp_dot_ff;
   logic [smv_pkg::CELL_W-1:0]    rsp_cell_ff;
   logic                          rsp_last_ff;

   logic                          accept, csr_acc, emit;
   logic [smv_pkg::DIM_W-1:0]     col_end, row_end_pos, hd7;
   logic                          is_last, col_wrap;
   logic [13:0]                   flat14;
   logic [smv_pkg::CELL_W-1:0]    flat;

   smv_pkg::fpu_req_type          fpu_req;
   logic [smv_pkg::DBL_W-1:0]     fpu_a, fpu_b, fpu_res, rd_data;
   logic                          fpu_done;
   logic                          mem_wr, mem_rd;
   logic [AW-1:0]                 mem_rd_addr;

   assign accept    = start && !busy;
   assign busy      = (st_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign csr_acc   = csr_valid && csr_ready;

   always_comb begin
      hd7         = smv_pkg::DIM_W'(hd_ff);
      col_end     = (gw_ff > {hd7[5:0], 1'b0}) ? gw_ff - hd7 : hd7 + 7'd1;
      row_end_pos = (gh_ff > {hd7[5:0], 1'b0}) ? gh_ff - hd7 : hd7 + 7'd1;
      col_wrap    = ({1'b0, col_ff} + 8'd1) >= {1'b0, col_end};
      is_last     = col_wrap && (({1'b0, row_ff} + 8'd1) >= {1'b0, row_end_pos});
      flat14      = 14'(row_ff) * 14'(gw_ff) + 14'(col_ff);
      flat        = flat14[smv_pkg::CELL_W-1:0];
   end

   assign mem_wr      = accept && (req_command == smv_pkg::CMD_LOAD);
   assign mem_rd      = (accept && (req_command == smv_pkg::CMD_ELEMENT)) || (st_ff == ST_R_RD);
   assign mem_rd_addr = (st_ff == ST_R_RD) ? AW'(flat) : AW'(req_cell_index);

   smv_vmem #(
      .DEPTH (VECTOR_DEPTH),
      .AW    (AW)
   ) u_vmem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (AW'(req_cell_index)),
      .wr_data (req_element_value),
      .rd_en   (mem_rd),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      fpu_req.start = 1'b0;
      fpu_req.op    = smv_pkg::FOP_MUL;
      fpu_a         = row_sum_ff;
      fpu_b         = rd_data;
      case (st_ff)
         ST_E_MUL: begin
            fpu_req.start = 1'b1;
            fpu_a         = value_ff;
         end
         ST_E_MW: begin
            fpu_req.start = fpu_done;
            fpu_req.op    = smv_pkg::FOP_ADD;
            fpu_b         = fpu_res;
         end
         ST_R_MUL: begin
            fpu_req.start = 1'b1;
         end
         ST_R_MW: begin
            fpu_req.start = fpu_done;
            fpu_req.op    = smv_pkg::FOP_ADD;
            fpu_a         = dot_ff;
            fpu_b         = fpu_res;
         end
         default: begin
         end
      endcase
   end

   smv_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .req    (fpu_req),
      .a_i    (fpu_a),
      .b_i    (fpu_b),
      .done_o (fpu_done),
      .res_o  (fpu_res)
   );

   assign emit = (st_ff == ST_R_AW) && fpu_done;

   always_comb begin
      st_in      = st_ff;
      row_sum_in = row_sum_ff;
      dot_in     = dot_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      gw_in      = gw_ff;
      gh_in      = gh_ff;
      hd_in      = hd_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  smv_pkg::CMD_ELEMENT: st_in = ST_E_MUL;
                  smv_pkg::CMD_ROW_END: st_in = ST_R_RD;
                  default:              st_in = ST_IDLE;
               endcase
            end
         end
         ST_E_MUL: st_in = ST_E_MW;
         ST_E_MW: begin
            if (fpu_done) begin
               st_in = ST_E_AW;
            end
         end
         ST_E_AW: begin
            if (fpu_done) begin
               row_sum_in = fpu_res;
               st_in      = row_end_ff ? ST_R_RD : ST_IDLE;
            end
         end
         ST_R_RD:  st_in = ST_R_MUL;
         ST_R_MUL: st_in = ST_R_MW;
         ST_R_MW: begin
            if (fpu_done) begin
               st_in = ST_R_AW;
            end
         end
         ST_R_AW: begin
            if (fpu_done) begin
               row_sum_in = smv_pkg::DBL_POS_ZERO;
               dot_in     = is_last ? smv_pkg::DBL_POS_ZERO : fpu_res;
               if (col_wrap) begin
                  col_in = hd7;
                  row_in = (({1'b0, row_ff} + 8'd1) >= {1'b0, row_end_pos}) ?
                           hd7 : row_ff + 7'd1;
               end else begin
                  col_in = col_ff + 7'd1;
               end
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (csr_acc) begin
         case (csr_index)
            smv_pkg::REG_GRID_WIDTH:  gw_in = csr_data;
            smv_pkg::REG_GRID_HEIGHT: gh_in = csr_data;
            smv_pkg::REG_HALO_DEPTH:  hd_in = csr_data[smv_pkg::HALO_W-1:0];
            default: begin
            end
         endcase
         if ((csr_index == smv_pkg::REG_GRID_WIDTH) || (csr_index == smv_pkg::REG_GRID_HEIGHT)
             || (csr_index == smv_pkg::REG_HALO_DEPTH)) begin
            row_sum_in = smv_pkg::DBL_POS_ZERO;
            dot_in     = smv_pkg::DBL_POS_ZERO;
            col_in     = smv_pkg::DIM_W'(hd_in);
            row_in     = smv_pkg::DIM_W'(hd_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         row_sum_ff   <= smv_pkg::DBL_POS_ZERO;
         dot_ff       <= smv_pkg::DBL_POS_ZERO;
         gw_ff        <= smv_pkg::GRID_WIDTH_RST;
         gh_ff        <= smv_pkg::GRID_HEIGHT_RST;
         hd_ff        <= smv_pkg::HALO_DEPTH_RST;
         col_ff       <= smv_pkg::DIM_W'(smv_pkg::HALO_DEPTH_RST);
         row_ff       <= smv_pkg::DIM_W'(smv_pkg::HALO_DEPTH_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         row_sum_ff   <= row_sum_in;
         dot_ff       <= dot_in;
         gw_ff        <= gw_in;
         gh_ff        <= gh_in;
         hd_ff        <= hd_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff   <= req_element_value;
         row_end_ff <= req_row_end;
      end
      if (emit) begin
         rsp_prod_ff <= row_sum_ff;
         rsp_cell_ff <= flat;
         rsp_dot_ff  <= fpu_res;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_product = rsp_prod_ff;
   assign rsp_row_cell    = rsp_cell_ff;
   assign rsp_dot_sum     = rsp_dot_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

>>> sv/smv_check.sv
// ----------------------------------------------------------------------------
// smv_check
// Port-level checks of the sparse matrix-vector block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module smv_check (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic [smv_pkg::CMD_W-1:0]  req_command,
   input wire logic                       rsp_valid,
   input wire logic                       csr_valid,
   input wire logic                       csr_ready
);

   // an element transfer always occupies the block
   a_elem_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == smv_pkg::CMD_ELEMENT) |=> busy)
      else $error("element transfer did not raise busy");

   // results are single-cycle strobes
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a load neither produces a result nor leaves the block busy
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == smv_pkg::CMD_LOAD) |=> !rsp_valid && !busy)
      else $error("load transfer produced activity");

   // reset leaves the block idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid && csr_ready)
      else $error("block not idle after reset");

   // no configuration transfer while working
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !busy)
      else $error("configuration transfer while busy");

endmodule

bind sparse_matvec_with_dot smv_check u_smv_check (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready)
);

`default_nettype wire
